>>> hw/rtl/line_pixel_address_generator_top_assert.svh
// assertion macros for the line pixel address generator
`ifndef LINE_PIXEL_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define LINE_PIXEL_ADDRESS_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define LPAG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpag assertion failed");

// next-cycle implication
`define LPAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpag assertion failed");

`endif

>>> hw/rtl/lpag_pkg.sv
// shared constants and types for the line pixel address generator
`timescale 1ns / 1ps

package lpag_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ADDR_BITS_DEF  = 32;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_BASE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PITCH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BPP        = 2'd2;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [7:0] ALPHA_BYTE     = 8'hFF;
    localparam logic [2:0] BPP_ALPHA      = 3'd4;
    localparam logic [2:0] BYTE_COUNT_RGB = 3'd3;
    localparam logic [2:0] BPP_RESET      = 3'd4;

    localparam int OUT_FIELD_BITS = 67;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] row_pitch;
        logic [2:0]  bytes_per_pixel;
    } t_cfg;

    typedef struct packed {
        logic [31:0] pixel_address;
        logic [31:0] pixel_value;
        logic [2:0]  byte_count;
        logic        last_pixel;
    } t_pixel_write;

endpackage

>>> hw/rtl/lpag_engine.sv
// bresenham line state and per-item address update
`timescale 1ns / 1ps

module lpag_engine #(
    parameter int COORD_BITS = lpag_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = lpag_pkg::ADDR_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic                    i_action,
    input  logic [COORD_BITS-1:0]   i_x_start,
    input  logic [COORD_BITS-1:0]   i_y_start,
    input  logic [COORD_BITS-1:0]   i_x_end,
    input  logic [COORD_BITS-1:0]   i_y_end,
    input  logic [7:0]              i_red,
    input  logic [7:0]              i_green,
    input  logic [7:0]              i_blue,
    input  lpag_pkg::t_cfg          i_cfg,
    output logic                    o_result_valid,
    output lpag_pkg::t_pixel_write  o_result,
    output logic                    o_line_active
);

    localparam int ERR_BITS = COORD_BITS + 3;

    logic                        r_active;
    logic [ADDR_BITS-1:0]        r_addr;
    logic signed [ERR_BITS-1:0]  r_err;
    logic [COORD_BITS-1:0]       r_left;
    logic [COORD_BITS:0]         r_twice_major;
    logic [COORD_BITS:0]         r_twice_minor;
    logic                        r_x_major;
    logic                        r_x_neg;
    logic                        r_y_neg;
    logic [23:0]                 r_color;

    // start item: deltas, directions, start address
    logic signed [COORD_BITS:0]  dx;
    logic signed [COORD_BITS:0]  dy;
    logic                        x_neg;
    logic                        y_neg;
    logic [COORD_BITS-1:0]       adx;
    logic [COORD_BITS-1:0]       ady;
    logic                        x_major;
    logic [COORD_BITS-1:0]       major;
    logic [COORD_BITS-1:0]       minor;
    logic signed [ERR_BITS-1:0]  err_init;
    logic [COORD_BITS+15:0]      row_off;
    logic [COORD_BITS+2:0]       col_off;
    logic [ADDR_BITS-1:0]        start_addr;

    // step item: error test and address moves
    logic [15:0]                 major_amt;
    logic [15:0]                 minor_amt;
    logic                        major_neg;
    logic                        minor_neg;
    logic                        err_ge;
    logic [ADDR_BITS-1:0]        addr_minor;
    logic [ADDR_BITS-1:0]        n_addr;
    logic signed [ERR_BITS-1:0]  err_minor;
    logic signed [ERR_BITS-1:0]  n_err;
    logic                        is_start;
    logic                        is_step;

    always_comb begin
        dx = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
        dy = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
        // zero delta counts as negative
        x_neg = dx[COORD_BITS] || (dx == '0);
        y_neg = dy[COORD_BITS] || (dy == '0);
        adx = x_neg ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady = y_neg ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        x_major = adx > ady;
        major = x_major ? adx : ady;
        minor = x_major ? ady : adx;
        err_init = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
        row_off = i_y_start * i_cfg.row_pitch;
        col_off = i_x_start * i_cfg.bytes_per_pixel;
        start_addr = ADDR_BITS'(i_cfg.frame_base) + ADDR_BITS'(row_off)
                   + ADDR_BITS'(col_off);
    end

    always_comb begin
        major_amt = r_x_major ? 16'(i_cfg.bytes_per_pixel) : i_cfg.row_pitch;
        minor_amt = r_x_major ? i_cfg.row_pitch : 16'(i_cfg.bytes_per_pixel);
        major_neg = r_x_major ? r_x_neg : r_y_neg;
        minor_neg = r_x_major ? r_y_neg : r_x_neg;
        err_ge = !r_err[ERR_BITS-1];
        if (!err_ge) begin
            addr_minor = r_addr;
        end else if (minor_neg) begin
            addr_minor = r_addr - ADDR_BITS'(minor_amt);
        end else begin
            addr_minor = r_addr + ADDR_BITS'(minor_amt);
        end
        if (major_neg) begin
            n_addr = addr_minor - ADDR_BITS'(major_amt);
        end else begin
            n_addr = addr_minor + ADDR_BITS'(major_amt);
        end
        err_minor = err_ge ? (r_err - $signed({2'b00, r_twice_major})) : r_err;
        n_err = err_minor + $signed({2'b00, r_twice_minor});
    end

    assign is_start = i_fire && (i_action == lpag_pkg::ACT_START);
    assign is_step  = i_fire && (i_action == lpag_pkg::ACT_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (is_start) begin
            r_active <= (major != '0);
        end else if (is_step && r_active && (r_left == COORD_BITS'(1))) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_start) begin
            r_addr        <= start_addr;
            r_err         <= err_init;
            r_left        <= major;
            r_twice_major <= {major, 1'b0};
            r_twice_minor <= {minor, 1'b0};
            r_x_major     <= x_major;
            r_x_neg       <= x_neg;
            r_y_neg       <= y_neg;
            r_color       <= {i_red, i_green, i_blue};
        end else if (is_step && r_active) begin
            r_addr <= n_addr;
            r_err  <= n_err;
            r_left <= r_left - COORD_BITS'(1);
        end
    end

    always_comb begin
        o_result_valid = is_step && r_active;
        o_result.pixel_address = 32'(r_addr);
        o_result.pixel_value = {lpag_pkg::ALPHA_BYTE, r_color};
        o_result.byte_count = (i_cfg.bytes_per_pixel == lpag_pkg::BPP_ALPHA)
                            ? lpag_pkg::BPP_ALPHA : lpag_pkg::BYTE_COUNT_RGB;
        o_result.last_pixel = (r_left == COORD_BITS'(1));
    end

    assign o_line_active = r_active;

endmodule

>>> hw/rtl/line_pixel_address_generator_top.sv
// top level of the line pixel address generator
//
// channel   dir  handshake                       content
// s_axis    in   s_axis_tvalid / s_axis_tready   start or step item
// m_axis    out  m_axis_tvalid / m_axis_tready   one pixel write
// cfg       in   i_cfg_we                        frame base, row pitch, bytes per pixel
//
// one item per cycle while the output register is not stalled; each result passes the input and output register
// start path: y times pitch and x times bytes-per-pixel multipliers plus the start address add
// step path: error test and two chained address add/subtract
// output register stalled: input register still takes one item, then ready drops
// synchronous active-low reset clears the line-active flag and valid flags and sets the config defaults
`timescale 1ns / 1ps

module line_pixel_address_generator_top #(
    parameter int COORD_BITS = lpag_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = lpag_pkg::ADDR_BITS_DEF,
    localparam int IN_FIELD_BITS = 4 * COORD_BITS + 24,
    localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_start, y_start, x_end, y_end, red, green, blue, zero pad
    input  logic [IN_TDATA_BITS-1:0]            s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_address, pixel_value, byte_count, zero pad
    output logic [lpag_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [lpag_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [lpag_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int OUT_PAD = lpag_pkg::OUT_TDATA_BITS - lpag_pkg::OUT_FIELD_BITS;
    localparam int CB = COORD_BITS;

    lpag_pkg::t_cfg          r_cfg;
    logic                    r_in_valid;
    logic                    r_in_action;
    logic [IN_FIELD_BITS-1:0] r_in_data;
    logic                    r_out_valid;
    lpag_pkg::t_pixel_write  r_out;

    logic                    advance;
    logic                    fire;
    logic                    res_valid;
    lpag_pkg::t_pixel_write  res;
    logic                    line_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base      <= '0;
            r_cfg.row_pitch       <= '0;
            r_cfg.bytes_per_pixel <= lpag_pkg::BPP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lpag_pkg::CFG_FRAME_BASE: r_cfg.frame_base <= i_cfg_data[31:0];
                lpag_pkg::CFG_ROW_PITCH:  r_cfg.row_pitch <= i_cfg_data[15:0];
                lpag_pkg::CFG_BPP:        r_cfg.bytes_per_pixel <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_data   <= s_axis_tdata[IN_FIELD_BITS-1:0];
        end
    end

    lpag_engine #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_action       (r_in_action),
        .i_x_start      (r_in_data[CB-1:0]),
        .i_y_start      (r_in_data[2*CB-1:CB]),
        .i_x_end        (r_in_data[3*CB-1:2*CB]),
        .i_y_end        (r_in_data[4*CB-1:3*CB]),
        .i_red          (r_in_data[4*CB+7:4*CB]),
        .i_green        (r_in_data[4*CB+15:4*CB+8]),
        .i_blue         (r_in_data[4*CB+23:4*CB+16]),
        .i_cfg          (r_cfg),
        .o_result_valid (res_valid),
        .o_result       (res),
        .o_line_active  (line_active)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {OUT_PAD'(0), r_out.byte_count, r_out.pixel_value,
                            r_out.pixel_address};
    assign m_axis_tlast  = r_out.last_pixel;

`include "line_pixel_address_generator_top_assert.svh"

    // a start item never yields a pixel write
    `LPAG_ASSERT_NEXT(a_start_no_result, i_clk, i_rst_n, fire && (r_in_action == lpag_pkg::ACT_START), !m_axis_tvalid)
    // a step with no active line yields nothing
    `LPAG_ASSERT_NEXT(a_idle_step_no_result, i_clk, i_rst_n, fire && (r_in_action == lpag_pkg::ACT_STEP) && !line_active, !m_axis_tvalid)
    // the last pixel closes the line
    `LPAG_ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n, fire && res_valid && res.last_pixel, !line_active)
    // a result only comes from an active line
    `LPAG_ASSERT_NOW(a_result_needs_line, i_clk, i_rst_n, res_valid, line_active && fire)

endmodule

>>> tb/tb_line_pixel_address_generator_top.sv
// testbench for the line pixel address generator: streams random lines and checks every pixel write
`timescale 1ns / 1ps

module tb_line_pixel_address_generator_top;
    import lpag_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int COORD_MAX     = 4095;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 90;
    localparam int PHASE_ITEMS   = 150;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] y_end;
        logic [11:0] x_end;
        logic [11:0] y_start;
        logic [11:0] x_start;
    } line_item_t;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_PATTERN, RX_COIN} rx_mode_t;

    class line_scoreboard;
        t_pixel_write pending_pixels[$];
        int           mismatches;
        int           pixels_checked;
        logic [31:0]  frame_base;
        logic [15:0]  row_pitch;
        logic [2:0]   bytes_per_pixel;
        bit           drawing;
        logic [31:0]  addr;
        int           err;
        int           left;
        int           major2;
        int           minor2;
        bit           x_major;
        bit           x_neg;
        bit           y_neg;
        logic [23:0]  color;

        function new();
            frame_base      = '0;
            row_pitch       = '0;
            bytes_per_pixel = BPP_RESET;
            drawing         = 0;
            addr            = '0;
            err             = 0;
            left            = 0;
            major2          = 0;
            minor2          = 0;
            x_major         = 0;
            x_neg           = 0;
            y_neg           = 0;
            color           = '0;
            mismatches      = 0;
            pixels_checked  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_FRAME_BASE: frame_base = data;
                CFG_ROW_PITCH:  row_pitch = data[15:0];
                CFG_BPP:        bytes_per_pixel = data[2:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] moved(logic [31:0] a, logic [31:0] amt, bit neg);
            return neg ? a - amt : a + amt;
        endfunction

        function void take_item(logic act, line_item_t it);
            int           dx;
            int           dy;
            int           major;
            int           minor;
            logic [31:0]  maj_amt;
            logic [31:0]  min_amt;
            bit           maj_neg;
            bit           min_neg;
            t_pixel_write px;
            if (act == ACT_START) begin
                dx = int'(it.x_end) - int'(it.x_start);
                dy = int'(it.y_end) - int'(it.y_start);
                // zero delta walks the negative way
                x_neg = !(dx > 0);
                if (x_neg) dx = -dx;
                y_neg = !(dy > 0);
                if (y_neg) dy = -dy;
                x_major = dx > dy;
                major   = x_major ? dx : dy;
                minor   = x_major ? dy : dx;
                major2  = 2 * major;
                minor2  = 2 * minor;
                err     = 2 * minor - major;
                left    = major;
                drawing = left != 0;
                color   = {it.red, it.green, it.blue};
                addr    = frame_base + 32'(it.y_start) * 32'(row_pitch)
                        + 32'(it.x_start) * 32'(bytes_per_pixel);
            end else if (drawing) begin
                px.pixel_address = addr;
                px.pixel_value   = {ALPHA_BYTE, color};
                px.byte_count    = (bytes_per_pixel == BPP_ALPHA) ? BPP_ALPHA : BYTE_COUNT_RGB;
                px.last_pixel    = (left == 1);
                pending_pixels.push_back(px);
                maj_amt = x_major ? 32'(bytes_per_pixel) : 32'(row_pitch);
                min_amt = x_major ? 32'(row_pitch) : 32'(bytes_per_pixel);
                maj_neg = x_major ? x_neg : y_neg;
                min_neg = x_major ? y_neg : x_neg;
                if (err >= 0) begin
                    err  -= major2;
                    addr  = moved(addr, min_amt, min_neg);
                end
                err  += minor2;
                addr  = moved(addr, maj_amt, maj_neg);
                left--;
                if (left == 0) drawing = 0;
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("mismatch %0d at %0t: %s", mismatches, $time, msg);
            end
        endtask

        task check_pixel(logic [OUT_TDATA_BITS-1:0] data, logic last);
            t_pixel_write want;
            pixels_checked++;
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel write with none pending");
                return;
            end
            want = pending_pixels.pop_front();
            if (data[31:0] !== want.pixel_address)
                report_mismatch($sformatf("address got %h want %h", data[31:0],
                                          want.pixel_address));
            if (data[63:32] !== want.pixel_value)
                report_mismatch($sformatf("value got %h want %h", data[63:32],
                                          want.pixel_value));
            if (data[66:64] !== want.byte_count)
                report_mismatch($sformatf("byte count got %0d want %0d", data[66:64],
                                          want.byte_count));
            if (last !== want.last_pixel)
                report_mismatch($sformatf("last got %b want %b", last, want.last_pixel));
        endtask
    endclass

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [71:0]                   s_axis_tdata  = '0;
    logic                          s_axis_tuser  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]     m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          i_cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data    = '0;

    line_scoreboard sb;
    int             burst_left    = 0;
    bit             dense         = 0;
    bit             hold_req      = 0;
    int             hold_left     = 0;
    logic [15:0]    rx_count      = '0;
    rx_mode_t       rx_mode       = RX_OPEN;
    int             lines_started = 0;
    int             settings_used = 0;
    int             useful_items  = 0;

    line_pixel_address_generator_top u_dut (.*);

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_item(s_axis_tuser, line_item_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata, m_axis_tlast);
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(negedge i_clk) begin
        rx_count++;
        if (rx_count[5:0] == 6'd0) rx_mode = rx_mode_t'($urandom_range(0, 3));
        if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_axis_tready <= ((rx_count % 7) < 4);
                default:    m_axis_tready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    function automatic int clip(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int major_of(int xs, int ys, int xe, int ye);
        int dx;
        int dy;
        dx = (xe > xs) ? xe - xs : xs - xe;
        dy = (ye > ys) ? ye - ys : ys - ye;
        return (dx > dy) ? dx : dy;
    endfunction

    task automatic send_item(logic act, line_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = dense ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= it;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_step();
        logic [71:0] junk;
        junk[31:0]  = $urandom;
        junk[63:32] = $urandom;
        junk[71:64] = $urandom_range(0, 255);
        send_item(ACT_STEP, line_item_t'(junk));
    endtask

    task automatic draw(int xs, int ys, int xe, int ye, int steps, logic [23:0] rgb);
        line_item_t it;
        it.x_start = xs[11:0];
        it.y_start = ys[11:0];
        it.x_end   = xe[11:0];
        it.y_end   = ye[11:0];
        it.red     = rgb[23:16];
        it.green   = rgb[15:8];
        it.blue    = rgb[7:0];
        send_item(ACT_START, it);
        lines_started++;
        repeat (steps) send_step();
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(logic [31:0] base, logic [15:0] pitch, logic [2:0] bpp);
        drain();
        cfg_write(CFG_FRAME_BASE, base);
        cfg_write(CFG_ROW_PITCH, {16'($urandom), pitch});
        cfg_write(CFG_BPP, {29'($urandom), bpp});
        cfg_write(CFG_UNUSED, $urandom);
        settings_used++;
    endtask

    // long line while the receiver holds off, so the input side backs up
    task automatic pressure_line();
        int xs;
        int ys;
        int xe;
        int ye;
        xs = $urandom_range(100, 3900);
        ys = $urandom_range(100, 3900);
        xe = ($urandom_range(0, 1) == 1) ? xs + 60 : xs - 60;
        ye = ys + $urandom_range(0, 120) - 60;
        @(posedge i_clk);
        hold_req = 1;
        draw(xs, ys, xe, ye, major_of(xs, ys, xe, ye), 24'($urandom));
        useful_items += 1 + major_of(xs, ys, xe, ye);
    endtask

    task automatic random_line();
        int kind;
        int xs;
        int ys;
        int xe;
        int ye;
        int span;
        int n;
        int d;
        kind = $urandom_range(0, 99);
        xs   = $urandom_range(0, COORD_MAX);
        ys   = $urandom_range(0, COORD_MAX);
        if ($urandom_range(0, 15) == 0) xs = $urandom_range(0, 1) * COORD_MAX;
        if ($urandom_range(0, 15) == 0) ys = $urandom_range(0, 1) * COORD_MAX;
        span = (kind < 94) ? 24 : COORD_MAX;
        xe   = clip(xs + $urandom_range(0, 2 * span) - span);
        ye   = clip(ys + $urandom_range(0, 2 * span) - span);
        if (kind >= 70 && kind < 80) begin
            d = $urandom_range(1, 15);
            case ($urandom_range(0, 2))
                0: begin
                    xe = clip(($urandom_range(0, 1) == 1) ? xs + d : xs - d);
                    ye = clip(($urandom_range(0, 1) == 1) ? ys + d : ys - d);
                end
                1: xe = xs;
                default: ye = ys;
            endcase
        end else if (kind >= 80 && kind < 84) begin
            xe = xs;
            ye = ys;
        end
        n = major_of(xs, ys, xe, ye);
        // broken sequences drop the line early; long lines only walk a stretch
        if (kind >= 84 && kind < 94) n = $urandom_range(0, n);
        if (kind >= 94 && n > 80) n = $urandom_range(10, 80);
        draw(xs, ys, xe, ye, n, 24'($urandom));
        useful_items += 1 + n;
        if ($urandom_range(0, 9) == 0) send_step();
    endtask

    initial begin
        int target;
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(32'h1000_0000, 16'd16384, 3'd4);
        send_step();
        draw(100, 200, 100, 200, 1, 24'h123456);
        draw(0, 0, 4, 0, 5, 24'hFF0080);
        draw(4095, 4095, 4092, 4093, 3, 24'h00FF7F);
        draw(7, 7, 10, 10, 3, 24'hFFFFFF);
        draw(0, 4095, 0, 4090, 2, 24'h000000);
        draw(4095, 0, 0, 4095, 2, 24'h5AA5C3);
        pressure_line();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_setting(32'hFFFF_FFF0, 16'hFFFF, 3'd3);
                1: apply_setting(32'h0, 16'h0, 3'd4);
                2: apply_setting($urandom, 16'($urandom), 3'd4);
                3: apply_setting($urandom, 16'($urandom_range(0, 8192)), 3'd7);
                4: apply_setting($urandom, 16'($urandom), 3'($urandom_range(0, 2)));
                default: apply_setting($urandom, 16'($urandom), 3'($urandom_range(3, 6)));
            endcase
            dense = (ph == 2);
            pressure_line();
            target = useful_items + PHASE_ITEMS;
            while (useful_items < target) random_line();
        end

        drain();
        $display("covered %0d lines over %0d register settings, %0d pixel writes checked",
                 lines_started, settings_used, sb.pixels_checked);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout with %0d pixel writes pending", sb.pending_pixels.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
